@@ design/qsc_pkg.sv @@
// qsc_pkg: shared constants, sample offset tables and pipeline control type
// for the quad sample coverage block. No dependencies.

package qsc_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 8;

	localparam int NUM_CORNERS  = 4;
	localparam int NUM_EDGES    = 5;
	localparam int NUM_SAMPLES  = 8;
	localparam int NUM_SAMPLES4 = 4;

	// sample pattern select
	localparam logic MODE_4X = 1'b0;
	localparam logic MODE_8X = 1'b1;

	// edges: E01, E12, E20 close triangle (c0,c1,c2); the reverse of E20,
	// E23 and E30 close triangle (c0,c2,c3)
	localparam int E01 = 0;
	localparam int E12 = 1;
	localparam int E20 = 2;
	localparam int E23 = 3;
	localparam int E30 = 4;

	localparam int EDGE_A [NUM_EDGES] = '{0, 1, 2, 2, 3};
	localparam int EDGE_B [NUM_EDGES] = '{1, 2, 0, 3, 0};

	// sample offsets in hundredths of a pixel
	localparam int OFFS4_X [NUM_SAMPLES4] = '{24, 74, 26, 76};
	localparam int OFFS4_Y [NUM_SAMPLES4] = '{26, 24, 76, 74};
	localparam int OFFS8_X [NUM_SAMPLES]  = '{20, 55, 90, 10, 40, 60, 35, 66};
	localparam int OFFS8_Y [NUM_SAMPLES]  = '{20, 10, 30, 70, 40, 55, 90, 81};

	// hundredths to fixed point, rounded to nearest, ties up
	function automatic int frac_off(input int hundredths, input int frac);
		return ((hundredths << frac) + 50) / 100;
	endfunction

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ctl_t;

endpackage

@@ design/qsc_in_if.sv @@
// qsc_in_if: input channel, pixel position and four corners per item.
// Depends on qsc_pkg for the default coordinate width.

interface qsc_in_if #(
	parameter int COORD_WIDTH = qsc_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pixel_x;
	logic signed [COORD_WIDTH-1:0] pixel_y;
	logic signed [COORD_WIDTH-1:0] corner0_x;
	logic signed [COORD_WIDTH-1:0] corner0_y;
	logic signed [COORD_WIDTH-1:0] corner1_x;
	logic signed [COORD_WIDTH-1:0] corner1_y;
	logic signed [COORD_WIDTH-1:0] corner2_x;
	logic signed [COORD_WIDTH-1:0] corner2_y;
	logic signed [COORD_WIDTH-1:0] corner3_x;
	logic signed [COORD_WIDTH-1:0] corner3_y;

	modport source (
		output valid, pixel_x, pixel_y, corner0_x, corner0_y, corner1_x, corner1_y,
		       corner2_x, corner2_y, corner3_x, corner3_y,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, corner0_x, corner0_y, corner1_x, corner1_y,
		       corner2_x, corner2_y, corner3_x, corner3_y,
		output ready
	);
endinterface

@@ design/qsc_out_if.sv @@
// qsc_out_if: result channel, one coverage mask per item.
// Depends on qsc_pkg for the sample count.

interface qsc_out_if;
	logic                             valid;
	logic                             ready;
	logic [qsc_pkg::NUM_SAMPLES-1:0]  coverage_mask;

	modport source (output valid, coverage_mask, input ready);
	modport sink (input valid, coverage_mask, output ready);
endinterface

@@ design/qsc_edge_setup.sv @@
// qsc_edge_setup: stage 1, per-edge coordinate differences for the pixel.
// Depends on qsc_pkg.

module qsc_edge_setup #(
	parameter int COORD_WIDTH = qsc_pkg::COORD_WIDTH,
	localparam int DW = COORD_WIDTH + 1
) (
	input  logic                          clk,
	input  qsc_pkg::pipe_ctl_t            ctl,
	input  logic                          mode,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] cx [qsc_pkg::NUM_CORNERS],
	input  logic signed [COORD_WIDTH-1:0] cy [qsc_pkg::NUM_CORNERS],
	output logic                          mode_s1,
	output logic signed [DW-1:0]          dpx_s1 [qsc_pkg::NUM_EDGES],
	output logic signed [DW-1:0]          dpy_s1 [qsc_pkg::NUM_EDGES],
	output logic signed [DW-1:0]          dx_s1  [qsc_pkg::NUM_EDGES],
	output logic signed [DW-1:0]          dy_s1  [qsc_pkg::NUM_EDGES]
);

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			mode_s1 <= mode;
		end
	end

	for (genvar e = 0; e < qsc_pkg::NUM_EDGES; e++) begin : g_edge
		localparam int A = qsc_pkg::EDGE_A[e];
		localparam int B = qsc_pkg::EDGE_B[e];
		always_ff @(posedge clk) begin
			if (ctl.ld_s1) begin
				dpx_s1[e] <= DW'(px) - DW'(cx[B]);
				dpy_s1[e] <= DW'(py) - DW'(cy[B]);
				dx_s1[e]  <= DW'(cx[A]) - DW'(cx[B]);
				dy_s1[e]  <= DW'(cy[A]) - DW'(cy[B]);
			end
		end
	end

endmodule

@@ design/qsc_edge_eval.sv @@
// qsc_edge_eval: stages 2 and 3. Edge function at the pixel corner plus the
// linear offset term of each sample, summed at full width.
// Depends on qsc_pkg.

module qsc_edge_eval #(
	parameter int COORD_WIDTH = qsc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = qsc_pkg::FRAC_BITS,
	localparam int DW = COORD_WIDTH + 1,
	localparam int EW = 2 * COORD_WIDTH + 4
) (
	input  logic                 clk,
	input  qsc_pkg::pipe_ctl_t   ctl,
	input  logic                 mode_s1,
	input  logic signed [DW-1:0] dpx_s1 [qsc_pkg::NUM_EDGES],
	input  logic signed [DW-1:0] dpy_s1 [qsc_pkg::NUM_EDGES],
	input  logic signed [DW-1:0] dx_s1  [qsc_pkg::NUM_EDGES],
	input  logic signed [DW-1:0] dy_s1  [qsc_pkg::NUM_EDGES],
	output logic                 mode_s3,
	output logic signed [EW-1:0] edge_s3 [qsc_pkg::NUM_SAMPLES][qsc_pkg::NUM_EDGES]
);

	localparam int PW = 2 * DW;
	localparam int OW = FRAC_BITS + 2;
	localparam int TW = DW + OW + 1;

	logic                 mode_s2;
	logic signed [PW-1:0] p_s2 [qsc_pkg::NUM_EDGES];
	logic signed [PW-1:0] q_s2 [qsc_pkg::NUM_EDGES];
	logic signed [TW-1:0] t_s2 [qsc_pkg::NUM_SAMPLES][qsc_pkg::NUM_EDGES];

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			mode_s2 <= mode_s1;
		end
		if (ctl.ld_s3) begin
			mode_s3 <= mode_s2;
		end
	end

	// E(pixel) = dpx*dy - dx*dpy
	for (genvar e = 0; e < qsc_pkg::NUM_EDGES; e++) begin : g_base
		always_ff @(posedge clk) begin
			if (ctl.ld_s2) begin
				p_s2[e] <= PW'(dpx_s1[e]) * PW'(dy_s1[e]);
				q_s2[e] <= PW'(dx_s1[e]) * PW'(dpy_s1[e]);
			end
		end
	end

	// E(pixel + o) = E(pixel) + ox*dy - dx*oy
	for (genvar k = 0; k < qsc_pkg::NUM_SAMPLES; k++) begin : g_smp
		localparam int OX8 = qsc_pkg::frac_off(qsc_pkg::OFFS8_X[k], FRAC_BITS);
		localparam int OY8 = qsc_pkg::frac_off(qsc_pkg::OFFS8_Y[k], FRAC_BITS);
		localparam int OX4 = qsc_pkg::frac_off(qsc_pkg::OFFS4_X[k % 4], FRAC_BITS);
		localparam int OY4 = qsc_pkg::frac_off(qsc_pkg::OFFS4_Y[k % 4], FRAC_BITS);
		logic signed [OW-1:0] ox;
		logic signed [OW-1:0] oy;

		always_comb begin
			if (k < qsc_pkg::NUM_SAMPLES4 && mode_s1 == qsc_pkg::MODE_4X) begin
				ox = OW'(OX4);
				oy = OW'(OY4);
			end else begin
				ox = OW'(OX8);
				oy = OW'(OY8);
			end
		end

		for (genvar e = 0; e < qsc_pkg::NUM_EDGES; e++) begin : g_edge
			always_ff @(posedge clk) begin
				if (ctl.ld_s2) begin
					t_s2[k][e] <= TW'(ox) * TW'(dy_s1[e]) - TW'(dx_s1[e]) * TW'(oy);
				end
				if (ctl.ld_s3) begin
					edge_s3[k][e] <= EW'(p_s2[e]) - EW'(q_s2[e]) + EW'(t_s2[k][e]);
				end
			end
		end
	end

endmodule

@@ design/qsc_cover.sv @@
// qsc_cover: stage 4, edge signs to per-triangle inside tests and the mask.
// Depends on qsc_pkg.

module qsc_cover #(
	parameter int COORD_WIDTH = qsc_pkg::COORD_WIDTH,
	localparam int EW = 2 * COORD_WIDTH + 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qsc_pkg::pipe_ctl_t               ctl,
	input  logic                             mode_s3,
	input  logic signed [EW-1:0]             edge_s3 [qsc_pkg::NUM_SAMPLES][qsc_pkg::NUM_EDGES],
	output logic [qsc_pkg::NUM_SAMPLES-1:0]  mask_s4
);

	logic [qsc_pkg::NUM_SAMPLES-1:0] hit;

	for (genvar k = 0; k < qsc_pkg::NUM_SAMPLES; k++) begin : g_smp
		logic [qsc_pkg::NUM_EDGES-1:0] neg;
		logic [qsc_pkg::NUM_EDGES-1:0] pos;
		logic in_a, in_b, used;

		for (genvar e = 0; e < qsc_pkg::NUM_EDGES; e++) begin : g_edge
			assign neg[e] = edge_s3[k][e][EW-1];
			assign pos[e] = !edge_s3[k][e][EW-1] && (|edge_s3[k][e]);
		end

		// second triangle walks the shared diagonal the other way: signs swap
		assign in_a = !((neg[qsc_pkg::E01] | neg[qsc_pkg::E12] | neg[qsc_pkg::E20]) &&
		                (pos[qsc_pkg::E01] | pos[qsc_pkg::E12] | pos[qsc_pkg::E20]));
		assign in_b = !((pos[qsc_pkg::E20] | neg[qsc_pkg::E23] | neg[qsc_pkg::E30]) &&
		                (neg[qsc_pkg::E20] | pos[qsc_pkg::E23] | pos[qsc_pkg::E30]));
		assign used = (k < qsc_pkg::NUM_SAMPLES4) || (mode_s3 == qsc_pkg::MODE_8X);
		assign hit[k] = used && (in_a || in_b);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			mask_s4 <= hit;
		end
	end

	a_upper_clear_4x: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_s4 && mode_s3 == qsc_pkg::MODE_4X |=>
		mask_s4[qsc_pkg::NUM_SAMPLES-1:qsc_pkg::NUM_SAMPLES4] == '0)
		else $error("upper mask bits set in four-sample mode");

endmodule

@@ design/quad_sample_coverage_core.sv @@
// quad_sample_coverage_core: top level, four-stage coverage pipeline with
// per-stage valid/ready and the sample_mode register.
// Depends on qsc_pkg, qsc_in_if, qsc_out_if, qsc_edge_setup, qsc_edge_eval, qsc_cover.
//
//  port      dir   handshake      payload
//  item      in    valid/ready    pixel_x/y, corner0..3_x/y
//  result    out   valid/ready    coverage_mask
//  sample_mode_we/wdata  in  write strobe, 1 bit
//
// One item per cycle sustained while results are taken; four register stages
// (differences, products, sums, sign test), the first loaded at the accepting
// edge and the result held in the sign-test stage until it is taken.
// Each stage holds its item while the next is full, so bubbles close up; a
// waiting result stops the input only once all four stages hold items.
// Reset clears all stage valid bits and sets sample_mode to the 4x pattern.

module quad_sample_coverage_core #(
	parameter int COORD_WIDTH = qsc_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = qsc_pkg::FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_mode_we,
	input  logic       sample_mode_wdata,
	qsc_in_if.sink     item,
	qsc_out_if.source  result
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int EW = 2 * COORD_WIDTH + 4;

	logic sample_mode_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	qsc_pkg::pipe_ctl_t ctl;

	logic signed [COORD_WIDTH-1:0] cx [qsc_pkg::NUM_CORNERS];
	logic signed [COORD_WIDTH-1:0] cy [qsc_pkg::NUM_CORNERS];

	logic                 mode_s1, mode_s3;
	logic signed [DW-1:0] dpx_s1 [qsc_pkg::NUM_EDGES];
	logic signed [DW-1:0] dpy_s1 [qsc_pkg::NUM_EDGES];
	logic signed [DW-1:0] dx_s1  [qsc_pkg::NUM_EDGES];
	logic signed [DW-1:0] dy_s1  [qsc_pkg::NUM_EDGES];
	logic signed [EW-1:0] edge_s3 [qsc_pkg::NUM_SAMPLES][qsc_pkg::NUM_EDGES];
	logic [qsc_pkg::NUM_SAMPLES-1:0] mask_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_mode_q <= qsc_pkg::MODE_4X;
		end else if (sample_mode_we) begin
			sample_mode_q <= sample_mode_wdata;
		end
	end

	assign rdy_s4 = !v_s4 || result.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign ctl.ld_s1 = rdy_s1 && item.valid;
	assign ctl.ld_s2 = rdy_s2 && v_s1;
	assign ctl.ld_s3 = rdy_s3 && v_s2;
	assign ctl.ld_s4 = rdy_s4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign item.ready           = rdy_s1;
	assign result.valid         = v_s4;
	assign result.coverage_mask = mask_s4;

	assign cx[0] = item.corner0_x;
	assign cx[1] = item.corner1_x;
	assign cx[2] = item.corner2_x;
	assign cx[3] = item.corner3_x;
	assign cy[0] = item.corner0_y;
	assign cy[1] = item.corner1_y;
	assign cy[2] = item.corner2_y;
	assign cy[3] = item.corner3_y;

	qsc_edge_setup #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_setup (
		.clk     (clk),
		.ctl     (ctl),
		.mode    (sample_mode_q),
		.px      (item.pixel_x),
		.py      (item.pixel_y),
		.cx      (cx),
		.cy      (cy),
		.mode_s1 (mode_s1),
		.dpx_s1  (dpx_s1),
		.dpy_s1  (dpy_s1),
		.dx_s1   (dx_s1),
		.dy_s1   (dy_s1)
	);

	qsc_edge_eval #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_eval (
		.clk     (clk),
		.ctl     (ctl),
		.mode_s1 (mode_s1),
		.dpx_s1  (dpx_s1),
		.dpy_s1  (dpy_s1),
		.dx_s1   (dx_s1),
		.dy_s1   (dy_s1),
		.mode_s3 (mode_s3),
		.edge_s3 (edge_s3)
	);

	qsc_cover #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_cover (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.mode_s3 (mode_s3),
		.edge_s3 (edge_s3),
		.mask_s4 (mask_s4)
	);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> v_s1)
		else $error("accepted item missing from stage 1");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s3 |=> v_s2)
		else $error("stalled item dropped from stage 2");

	a_s3_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy_s4 |=> v_s4)
		else $error("item lost between stage 3 and output");

endmodule

@@ test/quad_sample_coverage_core_test.sv @@
// Testbench for quad_sample_coverage_core: drives pixel/quad items, predicts each
// coverage mask and checks it against the block's result stream.
// Depends on qsc_pkg, qsc_in_if, qsc_out_if and the design sources.

module quad_sample_coverage_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [qsc_pkg::COORD_WIDTH-1:0] coord_t;
	typedef logic [qsc_pkg::NUM_SAMPLES-1:0] mask_t;

	typedef struct {
		coord_t px;
		coord_t py;
		coord_t cx [4];
		coord_t cy [4];
	} quad_item_t;

	localparam longint MAXC = (longint'(1) << (qsc_pkg::COORD_WIDTH - 1)) - 1;
	localparam longint MINC = -(longint'(1) << (qsc_pkg::COORD_WIDTH - 1));
	localparam longint PAT_A = -5592406;	// 24'hAAAAAA
	localparam longint PAT_5 = 5592405;	// 24'h555555
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int STALL_LEN = 300;

	// sample offsets in hundredths of a pixel
	localparam int OFF4_X [4] = '{24, 74, 26, 76};
	localparam int OFF4_Y [4] = '{26, 24, 76, 74};
	localparam int OFF8_X [8] = '{20, 55, 90, 10, 40, 60, 35, 66};
	localparam int OFF8_Y [8] = '{20, 10, 30, 70, 40, 55, 90, 81};
	localparam int SNAP_HUND [15] = '{10, 20, 24, 26, 30, 35, 40, 55, 60, 66, 70, 74, 76, 81, 90};

	logic clk = 1'b0;
	logic arst_n;
	logic sample_mode_we;
	logic sample_mode_wdata;

	qsc_in_if in_ch ();
	qsc_out_if out_ch ();

	quad_sample_coverage_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_mode_we    (sample_mode_we),
		.sample_mode_wdata (sample_mode_wdata),
		.item              (in_ch),
		.result            (out_ch)
	);

	logic mode_now;
	mask_t expected_masks [$];
	mask_t want;
	quad_item_t seen;
	int errors = 0;
	int quiet_cycles = 0;
	int send_gap_pct = 0;
	int take_gap_pct = 0;
	int stall_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- coverage predictor ----------------

	function automatic longint sample_offset(input int hundredths);
		return (hundredths * (1 << qsc_pkg::FRAC_BITS) + 50) / 100;
	endfunction

	// sign of (p-b) x (a-b), exact at 64 bits for these widths
	function automatic int side_of(input longint px, input longint py, input longint ax,
			input longint ay, input longint bx, input longint by);
		longint area2;
		area2 = (px - bx) * (ay - by) - (ax - bx) * (py - by);
		if (area2 < 0)
			return -1;
		return (area2 > 0) ? 1 : 0;
	endfunction

	// zero on an edge counts as inside; only mixed signs reject
	function automatic bit in_triangle(input longint px, input longint py,
			input longint ax, input longint ay, input longint bx, input longint by,
			input longint cx, input longint cy);
		int s1, s2, s3;
		s1 = side_of(px, py, ax, ay, bx, by);
		s2 = side_of(px, py, bx, by, cx, cy);
		s3 = side_of(px, py, cx, cy, ax, ay);
		return !((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0));
	endfunction

	function automatic mask_t predict_mask(input quad_item_t q, input logic mode);
		mask_t m;
		int n;
		longint sx, sy;
		longint x [4];
		longint y [4];
		m = '0;
		n = (mode == qsc_pkg::MODE_8X) ? 8 : 4;
		for (int i = 0; i < 4; i++) begin
			x[i] = longint'(q.cx[i]);
			y[i] = longint'(q.cy[i]);
		end
		for (int i = 0; i < n; i++) begin
			if (mode == qsc_pkg::MODE_8X) begin
				sx = longint'(q.px) + sample_offset(OFF8_X[i]);
				sy = longint'(q.py) + sample_offset(OFF8_Y[i]);
			end else begin
				sx = longint'(q.px) + sample_offset(OFF4_X[i]);
				sy = longint'(q.py) + sample_offset(OFF4_Y[i]);
			end
			if (in_triangle(sx, sy, x[0], y[0], x[1], y[1], x[2], y[2]) ||
					in_triangle(sx, sy, x[0], y[0], x[2], y[2], x[3], y[3]))
				m[i] = 1'b1;
		end
		return m;
	endfunction

	// ---------------- item construction ----------------

	function automatic coord_t clip(input longint v);
		if (v > MAXC)
			return coord_t'(MAXC);
		if (v < MINC)
			return coord_t'(MINC);
		return coord_t'(v);
	endfunction

	function automatic longint jitter(input int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic quad_item_t quad_of(input longint px, input longint py,
			input longint x0, input longint y0, input longint x1, input longint y1,
			input longint x2, input longint y2, input longint x3, input longint y3);
		quad_item_t q;
		q.px = clip(px);
		q.py = clip(py);
		q.cx[0] = clip(x0);
		q.cy[0] = clip(y0);
		q.cx[1] = clip(x1);
		q.cy[1] = clip(y1);
		q.cx[2] = clip(x2);
		q.cy[2] = clip(y2);
		q.cx[3] = clip(x3);
		q.cy[3] = clip(y3);
		return q;
	endfunction

	// corners sometimes land exactly on a sample coordinate so edges hit zero
	function automatic coord_t corner_near(input coord_t p, input int span);
		if ($urandom_range(3) == 0)
			return clip(longint'(p) + sample_offset(SNAP_HUND[$urandom_range(14)]) +
				256 * jitter(2));
		return clip(longint'(p) + jitter(span));
	endfunction

	function automatic quad_item_t random_quad();
		quad_item_t q;
		int kind, span;
		longint bx, by, dx, dy, k;
		kind = $urandom_range(99);
		q.px = coord_t'($urandom);
		q.py = coord_t'($urandom);
		if (kind < 15) begin
			for (int i = 0; i < 4; i++) begin
				q.cx[i] = coord_t'($urandom);
				q.cy[i] = coord_t'($urandom);
			end
			return q;
		end
		if (kind < 25) begin
			// collinear corners, repeats allowed
			bx = longint'(q.px) + jitter(512);
			by = longint'(q.py) + jitter(512);
			dx = jitter(300);
			dy = jitter(300);
			for (int i = 0; i < 4; i++) begin
				k = $urandom_range(3);
				q.cx[i] = clip(bx + k * dx);
				q.cy[i] = clip(by + k * dy);
			end
			return q;
		end
		if (kind < 32) begin
			q.px = $urandom_range(1) ? clip(MAXC - longint'($urandom_range(1024)))
				: clip(MINC + longint'($urandom_range(1024)));
			q.py = $urandom_range(1) ? clip(MAXC - longint'($urandom_range(1024)))
				: clip(MINC + longint'($urandom_range(1024)));
		end
		span = (kind < 40) ? 4096 : ($urandom_range(1) ? 256 : 768);
		for (int i = 0; i < 4; i++) begin
			q.cx[i] = corner_near(q.px, span);
			q.cy[i] = corner_near(q.py, span);
		end
		return q;
	endfunction

	// ---------------- channel drivers ----------------

	task automatic send_item(input quad_item_t q);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_x <= q.px;
		in_ch.pixel_y <= q.py;
		in_ch.corner0_x <= q.cx[0];
		in_ch.corner0_y <= q.cy[0];
		in_ch.corner1_x <= q.cx[1];
		in_ch.corner1_y <= q.cy[1];
		in_ch.corner2_x <= q.cx[2];
		in_ch.corner2_y <= q.cy[2];
		in_ch.corner3_x <= q.cx[3];
		in_ch.corner3_y <= q.cy[3];
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
	endtask

	// stop offering items and let the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		@(negedge clk);
		sample_mode_we <= 1'b1;
		sample_mode_wdata <= m;
		@(negedge clk);
		sample_mode_we <= 1'b0;
		mode_now = m;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_masks.size() == 0) begin
				$display("%0t: coverage_mask expected none actual %h", $time,
					out_ch.coverage_mask);
				errors++;
			end else begin
				want = expected_masks.pop_front();
				if (out_ch.coverage_mask !== want) begin
					$display("%0t: coverage_mask expected %h actual %h", $time, want,
						out_ch.coverage_mask);
					errors++;
				end
			end
		end
		if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			seen.px = in_ch.pixel_x;
			seen.py = in_ch.pixel_y;
			seen.cx[0] = in_ch.corner0_x;
			seen.cy[0] = in_ch.corner0_y;
			seen.cx[1] = in_ch.corner1_x;
			seen.cy[1] = in_ch.corner1_y;
			seen.cx[2] = in_ch.corner2_x;
			seen.cy[2] = in_ch.corner2_y;
			seen.cx[3] = in_ch.corner3_x;
			seen.cy[3] = in_ch.corner3_y;
			expected_masks.push_back(predict_mask(seen, mode_now));
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("quad_sample_coverage_core_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------- tests ----------------

	task automatic test_corner_cases();
		send_item(quad_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(quad_of(0, 0, 0, 0, 256, 0, 256, 256, 0, 256));
		send_item(quad_of(0, 0, 0, 256, 256, 256, 256, 0, 0, 0));
		send_item(quad_of(MAXC, MAXC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC));
		send_item(quad_of(MINC, MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC));
		send_item(quad_of(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
		// left edge passes exactly through samples at .26
		send_item(quad_of(0, 0, 67, 0, 512, 0, 512, 512, 67, 512));
		send_item(quad_of(0, 0, 0, 0, 100, 100, 200, 200, 300, 300));
		send_item(quad_of(0, 0, 0, 0, 0, 0, 256, 256, 0, 256));
		// self-intersecting and concave outlines
		send_item(quad_of(0, 0, 0, 0, 256, 256, 256, 0, 0, 256));
		send_item(quad_of(0, 0, 0, 0, 256, 0, 64, 64, 0, 256));
		send_item(quad_of(PAT_A, PAT_A, PAT_5, PAT_5, PAT_A, PAT_5, PAT_5, PAT_A, PAT_A, PAT_A));
		send_item(quad_of(PAT_5, PAT_5, PAT_A, PAT_A, PAT_5, PAT_A, PAT_A, PAT_5, PAT_5, PAT_5));
	endtask

	task automatic test_random_quads(input int count);
		for (int i = 0; i < count; i++) begin
			send_item(random_quad());
			if ($urandom_range(63) == 0)
				wait_idle();
		end
	endtask

	// hold results back long enough for the pipeline to fill and stall input
	task automatic test_output_stall(input int count);
		take_gap_pct = 0;
		send_gap_pct = 0;
		stall_left = STALL_LEN;
		for (int i = 0; i < count; i++)
			send_item(random_quad());
	endtask

	initial begin
		arst_n = 1'b0;
		sample_mode_we = 1'b0;
		sample_mode_wdata = 1'b0;
		mode_now = qsc_pkg::MODE_4X;
		out_ch.ready = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.pixel_x = '0;
		in_ch.pixel_y = '0;
		in_ch.corner0_x = '0;
		in_ch.corner0_y = '0;
		in_ch.corner1_x = '0;
		in_ch.corner1_y = '0;
		in_ch.corner2_x = '0;
		in_ch.corner2_y = '0;
		in_ch.corner3_x = '0;
		in_ch.corner3_y = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_gap_pct = 15;
		take_gap_pct = 74;
		test_corner_cases();
		wait_idle();
		set_mode(qsc_pkg::MODE_8X);
		test_corner_cases();
		test_random_quads(290);
		wait_idle();

		set_mode(qsc_pkg::MODE_4X);
		send_gap_pct = 74;
		take_gap_pct = 15;
		test_random_quads(290);
		wait_idle();

		set_mode(qsc_pkg::MODE_8X);
		send_gap_pct = 0;
		take_gap_pct = 0;
		test_random_quads(150);
		wait_idle();

		set_mode(qsc_pkg::MODE_4X);
		test_output_stall(100);
		wait_idle();

		if (errors == 0 && expected_masks.size() == 0)
			$display("quad_sample_coverage_core_test OK");
		else
			$display("quad_sample_coverage_core_test NOT OK");
		$finish;
	end

endmodule
